// ===== sv/ivc_pkg.sv =====
// shared types and constants of the irrigation valve controller
package ivc_pkg;

  // field widths
  localparam int HUM_W      = 7;
  localparam int SLOT_W     = 5;
  localparam int DOSE_W     = 16;
  localparam int CLKV_W     = 17;
  localparam int HOUR_W     = 5;
  localparam int MIN_W      = 6;
  localparam int LITRE_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int FC_W       = 7;
  localparam int OFS_W      = 8;
  localparam int BAND_W     = 5;
  localparam int LREM_W     = 9;
  localparam int REM_W      = 12;
  localparam int HRQ_W      = 6;

  // command codes
  localparam logic [2:0] CMD_EVAL   = 3'd0;
  localparam logic [2:0] CMD_TICK   = 3'd1;
  localparam logic [2:0] CMD_PULSE  = 3'd2;
  localparam logic [2:0] CMD_TARGET = 3'd3;
  localparam logic [2:0] CMD_DOSE   = 3'd4;
  localparam logic [2:0] CMD_CLOCK  = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_HOUR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MINUTE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_CAP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WILT_POINT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRY_OFFSET   = 3'd4;

  // reset values
  localparam logic [HUM_W-1:0]  TARGET_RST = 7'd19;
  localparam logic [FC_W-1:0]   FC_RST     = 7'd24;
  localparam logic [FC_W-1:0]   WP_RST     = 7'd7;
  localparam logic [BAND_W-1:0] BAND_RST   = 5'd4;

  // flow meter: 450 pulses per litre, 32-bit pulse count wraps at these values
  localparam logic [LREM_W-1:0]  PULSES_LAST    = 9'd449;
  localparam logic [LITRE_W-1:0] LITRES_AT_WRAP = 24'd9544371;
  localparam logic [LREM_W-1:0]  LREM_AT_WRAP   = 9'd345;

  // time constants
  localparam logic [MIN_W-1:0] LAST_SEC_MIN = 6'd59;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;

  // reciprocal multipliers for divide by constant
  localparam int HR_RECIP_W = 21;
  localparam logic [HR_RECIP_W-1:0] HR_RECIP = 21'd1193047;  // 2^32/3600
  localparam int HR_SHIFT = 32;
  localparam int MIN_RECIP_W = 13;
  localparam logic [MIN_RECIP_W-1:0] MIN_RECIP = 13'd4370;   // 2^18/60
  localparam int MIN_SHIFT = 18;
  localparam logic [7:0] BAND_RECIP = 8'd205;                // 2^10/5
  localparam int BAND_SHIFT = 10;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [HUM_W-1:0]  humidity;
    logic [SLOT_W-1:0] hour_index;
    logic [HUM_W-1:0]  target_value;
    logic [DOSE_W-1:0] dose_litres;
    logic [CLKV_W-1:0] clock_value;
  } in_item_t;

  typedef struct packed {
    logic               valve_open;
    logic               auto_demand;
    logic               dose_running;
    logic [LITRE_W-1:0] litres_delivered;
    logic [HOUR_W-1:0]  hour_now;
    logic [MIN_W-1:0]   minute_now;
  } out_item_t;

endpackage

// ===== sv/irrigation_valve_controller.sv =====
// irrigation valve controller: clock, flow count, dose schedule and humidity loop
// an accepted item's result is registered for the next cycle, except for set clock
// throughput: one item per cycle while in_stall is low; the result register frees
// when out_stall is low; set clock runs a short conversion (divide by 3600 and 60,
//   hour wrap) through DIV, REM, MIN, WRAP and DONE states, holding in_stall high
// synchronous active-low reset: clock and counts zero, valve closed, targets 19
module irrigation_valve_controller #(
  parameter int HOURS_PER_DAY = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ivc_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ivc_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [ivc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ivc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int HIDX_W = (HOURS_PER_DAY > 1) ? $clog2(HOURS_PER_DAY) : 1;
  localparam logic [ivc_pkg::HOUR_W-1:0] LAST_HOUR = ivc_pkg::HOUR_W'(HOURS_PER_DAY - 1);
  localparam logic [ivc_pkg::HRQ_W-1:0]  HOURS_Q   = ivc_pkg::HRQ_W'(HOURS_PER_DAY);
  localparam int HR_PROD_W  = ivc_pkg::CLKV_W + ivc_pkg::HR_RECIP_W;
  localparam int MIN_PROD_W = ivc_pkg::REM_W + ivc_pkg::MIN_RECIP_W;

  typedef enum logic [2:0] {
    CV_IDLE,
    CV_DIV,
    CV_REM,
    CV_MIN,
    CV_WRAP,
    CV_DONE
  } cv_state_t;

  // configuration
  logic [ivc_pkg::HOUR_W-1:0]  start_hour_r;
  logic [ivc_pkg::MIN_W-1:0]   start_min_r;
  logic [ivc_pkg::FC_W-1:0]    fc_r;
  logic [ivc_pkg::FC_W-1:0]    wp_r;
  logic [ivc_pkg::OFS_W-1:0]   offset_r;
  logic [ivc_pkg::BAND_W-1:0]  band_r;
  logic [ivc_pkg::FC_W+7:0]    band_prod;

  // controller state
  logic [ivc_pkg::HOUR_W-1:0]  hour_r, hour_nxt;
  logic [ivc_pkg::MIN_W-1:0]   min_r, min_nxt;
  logic [ivc_pkg::MIN_W-1:0]   sec_r, sec_nxt;
  logic [ivc_pkg::LITRE_W-1:0] litres_r, litres_nxt;
  logic [ivc_pkg::LREM_W-1:0]  lrem_r, lrem_nxt;
  logic [ivc_pkg::DOSE_W-1:0]  pending_r, pending_nxt;
  logic [ivc_pkg::LITRE_W-1:0] stop_r, stop_nxt;
  logic                        dosing_r, dosing_nxt;
  logic                        valve_r, valve_nxt;
  logic                        auto_r, auto_nxt;
  logic [ivc_pkg::HUM_W-1:0]   targets_r [HOURS_PER_DAY];

  // clock set conversion
  cv_state_t                   cv_state_r;
  logic [ivc_pkg::CLKV_W-1:0]  cv_v_r;
  logic [ivc_pkg::HRQ_W-1:0]   cv_hr_r;
  logic [ivc_pkg::REM_W-1:0]   cv_rem_r;
  logic [ivc_pkg::MIN_W-1:0]   cv_min_r;
  logic [HR_PROD_W-1:0]        hr_prod;
  logic [ivc_pkg::CLKV_W-1:0]  hr_secs;
  logic [ivc_pkg::CLKV_W-1:0]  rem_full;
  logic [MIN_PROD_W-1:0]       min_prod;
  logic [ivc_pkg::REM_W-1:0]   min_secs;
  logic [ivc_pkg::REM_W-1:0]   sec_full;

  // handshake and result
  logic                        out_valid_r;
  ivc_pkg::out_item_t          out_data_r, out_nxt;
  logic                        out_free;
  logic                        in_acc;
  logic                        out_load;

  // evaluate terms
  logic [ivc_pkg::HUM_W-1:0]   tgt;
  logic signed [9:0]           lower_th;
  logic [ivc_pkg::HUM_W:0]     upper_th;
  logic                        open_req;
  logic                        close_req;
  logic                        sched;

  // handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (cv_state_r != CV_IDLE) || !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_load  = (in_acc && (in_data.cmd != ivc_pkg::CMD_CLOCK)) ||
                     ((cv_state_r == CV_DONE) && out_free);

  // hysteresis band from field capacity, capacity / 5
  assign band_prod = {8'b0, cfg_data[ivc_pkg::FC_W-1:0]} * {7'b0, ivc_pkg::BAND_RECIP};

  // humidity thresholds for the current hour
  assign tgt      = targets_r[hour_r[HIDX_W-1:0]];
  assign lower_th = $signed({3'b0, tgt}) - $signed({5'b0, band_r}) - $signed({2'b0, offset_r});
  assign upper_th = {1'b0, tgt} + {3'b0, band_r};
  assign open_req = ($signed({3'b0, in_data.humidity}) <= lower_th) ||
                    (in_data.humidity <= wp_r);
  assign close_req = ({1'b0, in_data.humidity} >= upper_th) || (in_data.humidity >= fc_r);
  assign sched = (pending_r != '0) && (hour_r == start_hour_r) && (min_r == start_min_r);

  // clock set conversion arithmetic
  assign hr_prod  = {{ivc_pkg::HR_RECIP_W{1'b0}}, cv_v_r} *
                    {{ivc_pkg::CLKV_W{1'b0}}, ivc_pkg::HR_RECIP};
  assign hr_secs  = ivc_pkg::CLKV_W'(cv_hr_r) * ivc_pkg::CLKV_W'(ivc_pkg::SECS_PER_HOUR);
  assign rem_full = cv_v_r - hr_secs;
  assign min_prod = {{ivc_pkg::MIN_RECIP_W{1'b0}}, cv_rem_r} *
                    {{ivc_pkg::REM_W{1'b0}}, ivc_pkg::MIN_RECIP};
  assign min_secs = ivc_pkg::REM_W'(cv_min_r) * ivc_pkg::REM_W'(ivc_pkg::SECS_PER_MIN);
  assign sec_full = cv_rem_r - min_secs;

  // next state for one item
  always_comb begin
    hour_nxt    = hour_r;
    min_nxt     = min_r;
    sec_nxt     = sec_r;
    litres_nxt  = litres_r;
    lrem_nxt    = lrem_r;
    pending_nxt = pending_r;
    stop_nxt    = stop_r;
    dosing_nxt  = dosing_r;
    valve_nxt   = valve_r;
    auto_nxt    = auto_r;
    if (in_acc) begin
      unique case (in_data.cmd)
        ivc_pkg::CMD_EVAL: begin
          if (sched) begin
            stop_nxt   = litres_r + ivc_pkg::LITRE_W'(pending_r);
            valve_nxt  = 1'b1;
            dosing_nxt = 1'b1;
          end
          if (dosing_nxt) begin
            if (litres_r >= stop_nxt) begin
              pending_nxt = '0;
              dosing_nxt  = 1'b0;
              valve_nxt   = 1'b0;
            end
          end else begin
            if (open_req) begin
              valve_nxt = 1'b1;
              auto_nxt  = 1'b1;
            end
            if (close_req) begin
              valve_nxt = 1'b0;
              auto_nxt  = 1'b0;
            end
          end
          // midnight clear of the flow count
          if ((hour_r == '0) && (pending_nxt == '0)) begin
            litres_nxt = '0;
            lrem_nxt   = '0;
          end
        end
        ivc_pkg::CMD_TICK: begin
          if (sec_r == ivc_pkg::LAST_SEC_MIN) begin
            sec_nxt = '0;
            if (min_r == ivc_pkg::LAST_SEC_MIN) begin
              min_nxt  = '0;
              hour_nxt = (hour_r == LAST_HOUR) ? '0 : hour_r + 1'b1;
            end else begin
              min_nxt = min_r + 1'b1;
            end
          end else begin
            sec_nxt = sec_r + 1'b1;
          end
        end
        ivc_pkg::CMD_PULSE: begin
          if ((litres_r == ivc_pkg::LITRES_AT_WRAP) && (lrem_r == ivc_pkg::LREM_AT_WRAP)) begin
            litres_nxt = '0;
            lrem_nxt   = '0;
          end else if (lrem_r == ivc_pkg::PULSES_LAST) begin
            lrem_nxt   = '0;
            litres_nxt = litres_r + 1'b1;
          end else begin
            lrem_nxt = lrem_r + 1'b1;
          end
        end
        ivc_pkg::CMD_DOSE: begin
          pending_nxt = in_data.dose_litres;
        end
        default: begin
        end
      endcase
    end else if ((cv_state_r == CV_DONE) && out_free) begin
      hour_nxt = cv_hr_r[ivc_pkg::HOUR_W-1:0];
      min_nxt  = cv_min_r;
      sec_nxt  = sec_full[ivc_pkg::MIN_W-1:0];
    end
  end

  // result from the state after the item
  always_comb begin
    out_nxt.valve_open       = valve_nxt;
    out_nxt.auto_demand      = auto_nxt;
    out_nxt.dose_running     = dosing_nxt;
    out_nxt.litres_delivered = litres_nxt;
    out_nxt.hour_now         = hour_nxt;
    out_nxt.minute_now       = min_nxt;
  end

  // state, conversion sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_hour_r <= '0;
      start_min_r  <= '0;
      fc_r         <= ivc_pkg::FC_RST;
      wp_r         <= ivc_pkg::WP_RST;
      offset_r     <= '0;
      band_r       <= ivc_pkg::BAND_RST;
      hour_r       <= '0;
      min_r        <= '0;
      sec_r        <= '0;
      litres_r     <= '0;
      lrem_r       <= '0;
      pending_r    <= '0;
      stop_r       <= '0;
      dosing_r     <= 1'b0;
      valve_r      <= 1'b0;
      auto_r       <= 1'b0;
      for (int i = 0; i < HOURS_PER_DAY; i++) begin
        targets_r[i] <= ivc_pkg::TARGET_RST;
      end
      cv_state_r   <= CV_IDLE;
      out_valid_r  <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          ivc_pkg::CFG_START_HOUR:   start_hour_r <= cfg_data[ivc_pkg::HOUR_W-1:0];
          ivc_pkg::CFG_START_MINUTE: start_min_r  <= cfg_data[ivc_pkg::MIN_W-1:0];
          ivc_pkg::CFG_FIELD_CAP: begin
            fc_r   <= cfg_data[ivc_pkg::FC_W-1:0];
            band_r <= band_prod[ivc_pkg::BAND_SHIFT +: ivc_pkg::BAND_W];
          end
          ivc_pkg::CFG_WILT_POINT:   wp_r     <= cfg_data[ivc_pkg::FC_W-1:0];
          ivc_pkg::CFG_DRY_OFFSET:   offset_r <= cfg_data;
          default: begin
          end
        endcase
      end

      hour_r    <= hour_nxt;
      min_r     <= min_nxt;
      sec_r     <= sec_nxt;
      litres_r  <= litres_nxt;
      lrem_r    <= lrem_nxt;
      pending_r <= pending_nxt;
      stop_r    <= stop_nxt;
      dosing_r  <= dosing_nxt;
      valve_r   <= valve_nxt;
      auto_r    <= auto_nxt;

      // hourly target load, slots past the day are ignored
      if (in_acc && (in_data.cmd == ivc_pkg::CMD_TARGET) &&
          (in_data.hour_index < ivc_pkg::SLOT_W'(HOURS_PER_DAY))) begin
        targets_r[in_data.hour_index[HIDX_W-1:0]] <= in_data.target_value;
      end

      // clock set: hours, remainder, minutes, day wrap, then write
      unique case (cv_state_r)
        CV_IDLE: begin
          if (in_acc && (in_data.cmd == ivc_pkg::CMD_CLOCK)) begin
            cv_v_r     <= in_data.clock_value;
            cv_state_r <= CV_DIV;
          end
        end
        CV_DIV: begin
          cv_hr_r    <= hr_prod[ivc_pkg::HR_SHIFT +: ivc_pkg::HRQ_W];
          cv_state_r <= CV_REM;
        end
        CV_REM: begin
          cv_rem_r   <= rem_full[ivc_pkg::REM_W-1:0];
          cv_state_r <= CV_MIN;
        end
        CV_MIN: begin
          cv_min_r   <= min_prod[ivc_pkg::MIN_SHIFT +: ivc_pkg::MIN_W];
          cv_state_r <= CV_WRAP;
        end
        CV_WRAP: begin
          if (cv_hr_r >= HOURS_Q) begin
            cv_hr_r <= cv_hr_r - HOURS_Q;
          end else begin
            cv_state_r <= CV_DONE;
          end
        end
        CV_DONE: begin
          if (out_free) begin
            cv_state_r <= CV_IDLE;
          end
        end
        default: cv_state_r <= CV_IDLE;
      endcase

      // result register
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= out_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // a running dose always holds the valve open
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.dose_running || out_data.valve_open))
    else $error("dose running with valve closed");

  // time of day stays inside the day
  assert property (@(posedge clk) disable iff (!rst_n)
    (hour_r <= LAST_HOUR) && (min_r <= ivc_pkg::LAST_SEC_MIN) &&
    (sec_r <= ivc_pkg::LAST_SEC_MIN))
    else $error("time of day out of range");

  // pulse remainder stays below one litre
  assert property (@(posedge clk) disable iff (!rst_n)
    lrem_r <= ivc_pkg::PULSES_LAST)
    else $error("pulse remainder out of range");

  // an accepted clock set starts the conversion and gives no result yet
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_data.cmd == ivc_pkg::CMD_CLOCK)) |=> (cv_state_r == CV_DIV) && in_stall)
    else $error("clock set did not start conversion");

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench of the irrigation valve controller
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ivc_pkg::*;

  localparam int DAY_HOURS = 24;
  localparam int DAY_SECS = DAY_HOURS * SECS_PER_HOUR;
  localparam int PULSES_PER_LITRE = 450;
  localparam int LONG_HOLD = 80;
  localparam int MAX_SHOWN = 60;
  // command codes the block ignores
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  // status tracker: predicts the controller state after each item and checks results
  class valve_status_board;
    int start_hr, start_min, cap, wilt, dry_ofs;
    int unsigned secs, pulses, dose_pending, stop_at;
    bit dosing, valve, auto_on;
    int targets [DAY_HOURS];
    out_item_t due_status [$];
    int errors;

    function new();
      start_hr = 0;
      start_min = 0;
      cap = FC_RST;
      wilt = WP_RST;
      dry_ofs = 0;
      secs = 0;
      pulses = 0;
      dose_pending = 0;
      stop_at = 0;
      dosing = 1'b0;
      valve = 1'b0;
      auto_on = 1'b0;
      errors = 0;
      foreach (targets[i]) targets[i] = TARGET_RST;
    endfunction

    function int unsigned litres();
      return pulses / PULSES_PER_LITRE;
    endfunction

    function int unsigned hour_now();
      return (secs / SECS_PER_HOUR) % DAY_HOURS;
    endfunction

    function int unsigned minute_now();
      return (secs / SECS_PER_MIN) % 60;
    endfunction

    function bit at_start_time();
      return hour_now() == start_hr && minute_now() == start_min;
    endfunction

    function void set_config(int sh, int sm, int fc, int wp, int ofs);
      start_hr = sh;
      start_min = sm;
      cap = fc;
      wilt = wp;
      dry_ofs = ofs;
    endfunction

    // apply one accepted item and queue the status it must produce
    function void note_command(in_item_t it);
      int hr, band, tgt, hum;
      out_item_t st;
      hum = it.humidity;
      case (it.cmd)
        CMD_EVAL: begin
          hr = hour_now();
          band = cap / 5;
          tgt = targets[hr];
          // scheduled start, re-armed on every evaluation in that minute
          if (dose_pending != 0 && at_start_time()) begin
            stop_at = litres() + dose_pending;
            valve = 1'b1;
            dosing = 1'b1;
          end
          if (dosing) begin
            if (litres() >= stop_at) begin
              dose_pending = 0;
              dosing = 1'b0;
              valve = 1'b0;
            end
          end else begin
            // humidity loop, closing wins
            if (hum <= tgt - band - dry_ofs || hum <= wilt) begin
              valve = 1'b1;
              auto_on = 1'b1;
            end
            if (hum >= tgt + band || hum >= cap) begin
              valve = 1'b0;
              auto_on = 1'b0;
            end
          end
          // midnight clear of the flow count
          if (hr == 0 && dose_pending == 0) pulses = 0;
        end
        CMD_TICK: begin
          secs = secs + 1;
          if (secs >= DAY_SECS) secs = 0;
        end
        CMD_PULSE: pulses = pulses + 1;
        CMD_TARGET: begin
          if (it.hour_index < DAY_HOURS) targets[it.hour_index] = it.target_value;
        end
        CMD_DOSE: dose_pending = it.dose_litres;
        CMD_CLOCK: secs = it.clock_value % DAY_SECS;
        default: ;
      endcase
      st.valve_open = valve;
      st.auto_demand = auto_on;
      st.dose_running = dosing;
      st.litres_delivered = LITRE_W'(litres());
      st.hour_now = HOUR_W'(hour_now());
      st.minute_now = MIN_W'(minute_now());
      due_status.push_back(st);
    endfunction

    function void flag_field(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      // keep the log short when the block is badly off
      if (errors <= MAX_SHOWN)
        $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    endfunction

    function void check_status(out_item_t got);
      out_item_t want;
      if (due_status.size() == 0) begin
        errors++;
        $display("%0t: status item with none expected, expected nothing got %p", $time, got);
        return;
      end
      want = due_status.pop_front();
      if (got.valve_open !== want.valve_open)
        flag_field("valve_open", want.valve_open, got.valve_open);
      if (got.auto_demand !== want.auto_demand)
        flag_field("auto_demand", want.auto_demand, got.auto_demand);
      if (got.dose_running !== want.dose_running)
        flag_field("dose_running", want.dose_running, got.dose_running);
      if (got.litres_delivered !== want.litres_delivered)
        flag_field("litres_delivered", want.litres_delivered, got.litres_delivered);
      if (got.hour_now !== want.hour_now)
        flag_field("hour_now", want.hour_now, got.hour_now);
      if (got.minute_now !== want.minute_now)
        flag_field("minute_now", want.minute_now, got.minute_now);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  valve_status_board sb;
  bit steady = 1'b0;
  bit long_hold_req = 1'b0;
  int items_sent = 0;

  irrigation_valve_controller #(
    .HOURS_PER_DAY(DAY_HOURS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) sb.check_status(out_data);
  end

  // result sink: random stalls per item, one long hold on request
  initial begin : result_sink
    int hold;
    forever begin
      hold = steady ? 0 : $urandom_range(0, 9);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("irrigation_valve_controller regression: fail");
    $finish;
  end

  function automatic in_item_t random_item(logic [2:0] c);
    in_item_t it;
    it.cmd = c;
    it.humidity = $urandom_range(0, 100);
    it.hour_index = $urandom_range(0, 31);
    it.target_value = $urandom_range(0, 100);
    it.dose_litres = $urandom_range(0, 65535);
    it.clock_value = $urandom_range(0, 131071);
    return it;
  endfunction

  // humidity around the switching thresholds of the current hour
  function automatic int edge_humidity();
    int tgt, v;
    tgt = sb.targets[sb.hour_now()];
    case ($urandom_range(0, 4))
      0: v = tgt - sb.cap / 5 - sb.dry_ofs;
      1: v = tgt + sb.cap / 5;
      2: v = sb.wilt;
      3: v = sb.cap;
      default: v = $urandom_range(0, 100);
    endcase
    v = v + int'($urandom_range(0, 2)) - 1;
    if (v < 0) v = 0;
    if (v > 100) v = 100;
    return v;
  endfunction

  // one item through the input handshake
  task automatic drive_item(in_item_t it);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_command(it);
    items_sent++;
  endtask

  task automatic send(in_item_t it);
    in_item_t fix;
    // a dose of more than one litre would take hundreds of pulses to finish
    if (it.cmd == CMD_EVAL && sb.dose_pending > 1 && sb.at_start_time()) begin
      fix = random_item(CMD_DOSE);
      fix.dose_litres = 1;
      drive_item(fix);
    end
    drive_item(it);
  endtask

  task automatic send_cmd(logic [2:0] c);
    send(random_item(c));
  endtask

  task automatic send_eval();
    in_item_t it;
    it = random_item(CMD_EVAL);
    it.humidity = HUM_W'(edge_humidity());
    send(it);
  endtask

  // leave the start minute and feed pulses until the running dose stops
  task automatic finish_dose();
    in_item_t it;
    int hr;
    hr = (sb.start_hr == 5) ? 6 : 5;
    it = random_item(CMD_CLOCK);
    it.clock_value = CLKV_W'(hr * SECS_PER_HOUR + $urandom_range(0, SECS_PER_HOUR - 1));
    send(it);
    while (sb.dosing) begin
      if ($urandom_range(0, 29) == 0) send_eval();
      else send_cmd(CMD_PULSE);
    end
  endtask

  // well-formed dose: set clock just before the start, request one litre, evaluate
  task automatic run_schedule();
    in_item_t it;
    int lead;
    lead = $urandom_range(0, 3);
    it = random_item(CMD_CLOCK);
    it.clock_value = CLKV_W'((sb.start_hr * SECS_PER_HOUR + sb.start_min * SECS_PER_MIN
                              + DAY_SECS - lead) % DAY_SECS);
    send(it);
    it = random_item(CMD_DOSE);
    it.dose_litres = 1;
    send(it);
    repeat ($urandom_range(3, 8)) begin
      case ($urandom_range(0, 3))
        0: send_cmd(CMD_TICK);
        1: send_cmd(CMD_PULSE);
        default: send_eval();
      endcase
    end
    // cancel while the dose may be running
    if ($urandom_range(0, 1) == 1) begin
      it = random_item(CMD_DOSE);
      it.dose_litres = 0;
      send(it);
    end
    send_eval();
    if (sb.dosing) finish_dose();
  endtask

  // random phase built from short command sequences
  task automatic random_phase(int count, bit with_dose);
    in_item_t it;
    int first, at, h, m, k, v;
    bit scheduled;
    first = items_sent;
    at = $urandom_range(0, count / 2);
    scheduled = !with_dose;
    while (items_sent - first < count) begin
      steady = ($urandom_range(0, 4) == 0);
      if (!scheduled && items_sent - first >= at) begin
        scheduled = 1'b1;
        run_schedule();
      end else begin
        case ($urandom_range(0, 5))
          // noise, any command
          0: repeat ($urandom_range(1, 8)) send_cmd(3'($urandom_range(0, 7)));
          // humidity loop around the thresholds
          1: begin
            if ($urandom_range(0, 1) == 1) begin
              it = random_item(CMD_TARGET);
              it.hour_index = SLOT_W'(sb.hour_now());
              send(it);
            end
            repeat ($urandom_range(2, 6)) send_eval();
          end
          // clock near a minute, hour or day boundary, then ticks across it
          2: begin
            h = $urandom_range(0, DAY_HOURS - 1);
            m = $urandom_range(0, 59);
            k = $urandom_range(0, 3);
            case ($urandom_range(0, 3))
              0: v = DAY_SECS - 1 - k;
              1: v = h * SECS_PER_HOUR + SECS_PER_HOUR - 1 - k;
              2: v = h * SECS_PER_HOUR + m * SECS_PER_MIN + SECS_PER_MIN - 1 - k;
              default: v = $urandom_range(0, DAY_SECS - 1);
            endcase
            it = random_item(CMD_CLOCK);
            it.clock_value = CLKV_W'(v);
            send(it);
            repeat (k + $urandom_range(1, 3)) send_cmd(CMD_TICK);
            send_eval();
          end
          // flow burst
          3: begin
            repeat ($urandom_range(1, 30)) send_cmd(CMD_PULSE);
            send_eval();
          end
          // dose request, sometimes cancelled
          4: begin
            send_cmd(CMD_DOSE);
            send_eval();
            if ($urandom_range(0, 1) == 1) begin
              it = random_item(CMD_DOSE);
              it.dose_litres = 0;
              send(it);
            end
          end
          // out of range slot or clock, spare codes
          default: begin
            case ($urandom_range(0, 2))
              0: begin
                it = random_item(CMD_TARGET);
                it.hour_index = SLOT_W'($urandom_range(DAY_HOURS, 31));
              end
              1: begin
                it = random_item(CMD_CLOCK);
                it.clock_value = CLKV_W'($urandom_range(DAY_SECS, 131071));
              end
              default: it = random_item($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B);
            endcase
            send(it);
            send_eval();
          end
        endcase
      end
      if (sb.dosing) finish_dose();
    end
  endtask

  // wait for every expected status, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.due_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write all five registers while the block is idle
  task automatic load_settings(int sh, int sm, int fc, int wp, int ofs);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [CFG_DATA_W-1:0] vals [5];
    idx = '{CFG_START_HOUR, CFG_START_MINUTE, CFG_FIELD_CAP, CFG_WILT_POINT, CFG_DRY_OFFSET};
    vals = '{CFG_DATA_W'(sh), CFG_DATA_W'(sm), CFG_DATA_W'(fc), CFG_DATA_W'(wp),
             CFG_DATA_W'(ofs)};
    cfg_we <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    sb.set_config(sh, sm, fc, wp, ofs);
  endtask

  // main sequence
  initial begin : stimulus
    in_item_t it;
    int hums [6];
    sb = new();
    hums = '{0, 100, 19, 15, 16, 23};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset-like settings, thresholds, wraps, ignored codes, dose cancel
    load_settings(0, 0, FC_RST, WP_RST, 0);
    foreach (hums[i]) begin
      it = random_item(CMD_EVAL);
      it.humidity = HUM_W'(hums[i]);
      send(it);
    end
    send_cmd(CMD_TICK);
    send_cmd(CMD_PULSE);
    it = random_item(CMD_TARGET);
    it.hour_index = 23;
    it.target_value = 100;
    send(it);
    it.hour_index = 31;
    it.target_value = 0;
    send(it);
    it.hour_index = 0;
    send(it);
    // target zero: lower threshold goes negative
    it = random_item(CMD_EVAL);
    it.humidity = 0;
    send(it);
    it = random_item(CMD_CLOCK);
    it.clock_value = CLKV_W'(DAY_SECS - 1);
    send(it);
    send_cmd(CMD_TICK);
    it.clock_value = 17'h1ffff;
    send(it);
    it.clock_value = CLKV_W'(DAY_SECS);
    send(it);
    send_cmd(CMD_SPARE_A);
    send_cmd(CMD_SPARE_B);
    it = random_item(CMD_DOSE);
    it.dose_litres = 16'hffff;
    send(it);
    it.dose_litres = 0;
    send(it);
    it.dose_litres = 1;
    send(it);
    it = random_item(CMD_EVAL);
    it.humidity = 50;
    send(it);
    it = random_item(CMD_DOSE);
    it.dose_litres = 0;
    send(it);
    it = random_item(CMD_EVAL);
    it.humidity = 0;
    send(it);
    if (sb.dosing) finish_dose();
    settle();

    // random settings
    load_settings($urandom_range(1, 22), $urandom_range(0, 59), $urandom_range(10, 60),
                  $urandom_range(0, 15), $urandom_range(0, 20));
    long_hold_req = 1'b1;
    random_phase(200, 1'b0);
    settle();

    // upper extremes, start at the last minute of the day
    load_settings(23, 59, 100, 100, 255);
    long_hold_req = 1'b1;
    random_phase(150, 1'b1);
    settle();

    // lower extremes
    load_settings(0, 0, 0, 0, 0);
    random_phase(150, 1'b0);
    settle();

    if (sb.errors == 0 && sb.due_status.size() == 0) begin
      $display("irrigation_valve_controller regression: pass");
    end else begin
      $display("irrigation_valve_controller regression: fail");
    end
    $finish;
  end

endmodule
